// ===== hw/rtl/dpjq_pkg.sv =====
package dpjq_pkg;

    // Result codes
    typedef enum logic [2:0] {
        ST_INSERTED = 3'd0,
        ST_DROPPED  = 3'd1,
        ST_REPLACED = 3'd2,
        ST_FULL     = 3'd3,
        ST_DEQUEUED = 3'd4,
        ST_EMPTY    = 3'd5
    } status_t;

    // Request operations
    localparam logic OP_ENQ = 1'b0;
    localparam logic OP_DEQ = 1'b1;

    // Job kinds
    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_SAVE = 1'b1;

    // Sequencer states
    typedef enum logic [2:0] {
        SQ_IDLE,
        SQ_SCAN,
        SQ_DECIDE,
        SQ_SHIFT,
        SQ_WRITE,
        SQ_DONE
    } seq_state_t;

endpackage

// ===== hw/rtl/dpjq_req_if.sv =====
interface dpjq_req_if #(
    parameter int TAG_WIDTH      = 32,
    parameter int PRIORITY_WIDTH = 16
);
    logic                             valid;
    logic                             ready;
    logic                             opcode;
    logic                             job_kind;
    logic signed [PRIORITY_WIDTH-1:0] job_priority;
    logic [TAG_WIDTH-1:0]             chunk_tag;
    logic [7:0]                       active_loads;
    logic [7:0]                       active_saves;

    modport source (
        output valid, opcode, job_kind, job_priority, chunk_tag, active_loads, active_saves,
        input  ready
    );
    modport sink (
        input  valid, opcode, job_kind, job_priority, chunk_tag, active_loads, active_saves,
        output ready
    );
endinterface

// ===== hw/rtl/dpjq_rsp_if.sv =====
interface dpjq_rsp_if #(
    parameter int TAG_WIDTH      = 32,
    parameter int PRIORITY_WIDTH = 16,
    parameter int COUNT_WIDTH    = 5
);
    logic                             valid;
    logic                             ready;
    dpjq_pkg::status_t                status;
    logic                             out_kind;
    logic signed [PRIORITY_WIDTH-1:0] out_priority;
    logic [TAG_WIDTH-1:0]             out_chunk_tag;
    logic [COUNT_WIDTH-1:0]           queue_count;

    modport source (
        output valid, status, out_kind, out_priority, out_chunk_tag, queue_count,
        input  ready
    );
    modport sink (
        input  valid, status, out_kind, out_priority, out_chunk_tag, queue_count,
        output ready
    );
endinterface

// ===== hw/rtl/dpjq_store.sv =====
module dpjq_store #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 49
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

// ===== hw/rtl/dedup_priority_job_queue_unit.sv =====
// Channel  Dir  Word
// req      in   opcode, job_kind, job_priority, chunk_tag, active_loads, active_saves
// rsp      out  status, out_kind, out_priority, out_chunk_tag, queue_count
//
// One request is handled at a time: unless the queue is empty, a scan reads each held
// entry once from the job memory, then a shift moves entries one a cycle through the
// same memory port, then the new job is written on an insert or a replace.
// rst_n clears the held count and the sequencer; the memory needs no clearing.
// The result sits in an output register; the next request is taken while it waits.
module dedup_priority_job_queue_unit #(
    parameter int QUEUE_DEPTH    = 16,
    parameter int TAG_WIDTH      = 32,
    parameter int PRIORITY_WIDTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    dpjq_req_if.sink    req,
    dpjq_rsp_if.source  rsp
);
    import dpjq_pkg::*;

    localparam int IDX_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int ENT_W = 1 + PRIORITY_WIDTH + TAG_WIDTH;

    seq_state_t state_reg, state_next;

    logic [CNT_W-1:0]                count_reg;
    logic                            out_vld_reg;
    status_t                         status_reg;
    logic                            res_kind_reg;
    logic signed [PRIORITY_WIDTH-1:0] res_prio_reg;
    logic [TAG_WIDTH-1:0]            res_tag_reg;

    // Captured request
    logic                            op_reg;
    logic                            kind_reg;
    logic signed [PRIORITY_WIDTH-1:0] prio_reg;
    logic [TAG_WIDTH-1:0]            tag_reg;
    logic                            favored_reg;

    // Scan state
    logic [CNT_W-1:0]                rd_idx_reg;
    logic                            cmp_vld_reg;
    logic [CNT_W-1:0]                cmp_idx_reg;
    logic                            found_reg;
    logic [CNT_W-1:0]                match_reg;
    logic                            mkind_reg;
    logic signed [PRIORITY_WIDTH-1:0] mprio_reg;
    logic                            pos0_vld_reg;
    logic [CNT_W-1:0]                pos0_reg;
    logic                            posx_vld_reg;
    logic [CNT_W-1:0]                posx_reg;
    logic                            fav_vld_reg;
    logic [CNT_W-1:0]                pick_reg;
    logic                            pkind_reg;
    logic signed [PRIORITY_WIDTH-1:0] pprio_reg;
    logic [TAG_WIDTH-1:0]            ptag_reg;

    // Shift state
    logic                            right_reg;
    logic [CNT_W-1:0]                src_reg;
    logic [CNT_W-1:0]                left_reg;
    logic                            wnew_reg;
    logic [CNT_W-1:0]                newpos_reg;
    logic                            wr_pend_reg;
    logic [CNT_W-1:0]                wr_addr_reg;

    // Memory ports
    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    logic [ENT_W-1:0] mem_wdata;
    logic [IDX_W-1:0] mem_raddr;
    logic [ENT_W-1:0] mem_rdata;

    logic                            e_kind;
    logic signed [PRIORITY_WIDTH-1:0] e_prio;
    logic [TAG_WIDTH-1:0]            e_tag;
    logic                            first_hit;
    logic                            scan_issue;
    logic                            shift_issue;
    logic                            load_out;
    logic                            accept;
    logic [CNT_W-1:0]                pos0_eff;
    logic [CNT_W-1:0]                posx_eff;

    dpjq_store #(
        .DEPTH (QUEUE_DEPTH),
        .WIDTH (ENT_W)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign e_kind    = mem_rdata[ENT_W-1];
    assign e_prio    = mem_rdata[ENT_W-2 -: PRIORITY_WIDTH];
    assign e_tag     = mem_rdata[TAG_WIDTH-1:0];
    assign first_hit = (e_tag == tag_reg) && !found_reg;
    assign pos0_eff  = pos0_vld_reg ? pos0_reg : count_reg;
    assign posx_eff  = posx_vld_reg ? posx_reg : count_reg;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            SQ_IDLE:
            begin
                if (req.valid)
                begin
                    state_next = (count_reg == '0) ? SQ_DECIDE : SQ_SCAN;
                end
            end
            SQ_SCAN:
            begin
                if (rd_idx_reg == count_reg && !cmp_vld_reg)
                begin
                    state_next = SQ_DECIDE;
                end
            end
            SQ_DECIDE:
            begin
                state_next = SQ_SHIFT;
            end
            SQ_SHIFT:
            begin
                if (left_reg == '0 && !wr_pend_reg)
                begin
                    state_next = SQ_WRITE;
                end
            end
            SQ_WRITE:
            begin
                state_next = SQ_DONE;
            end
            SQ_DONE:
            begin
                if (!out_vld_reg || rsp.ready)
                begin
                    state_next = SQ_IDLE;
                end
            end
            default:
            begin
                state_next = SQ_IDLE;
            end
        endcase
    end

    // Sequencer outputs: handshake and memory control
    always_comb
    begin
        req.ready   = 1'b0;
        scan_issue  = 1'b0;
        shift_issue = 1'b0;
        load_out    = 1'b0;
        mem_we      = 1'b0;
        mem_waddr   = wr_addr_reg[IDX_W-1:0];
        mem_wdata   = mem_rdata;
        mem_raddr   = rd_idx_reg[IDX_W-1:0];
        case (state_reg)
            SQ_IDLE:
            begin
                req.ready = 1'b1;
            end
            SQ_SCAN:
            begin
                scan_issue = (rd_idx_reg < count_reg);
            end
            SQ_SHIFT:
            begin
                shift_issue = (left_reg != '0);
                mem_raddr   = src_reg[IDX_W-1:0];
                mem_we      = wr_pend_reg;
            end
            SQ_WRITE:
            begin
                mem_we    = wnew_reg;
                mem_waddr = newpos_reg[IDX_W-1:0];
                mem_wdata = {kind_reg, prio_reg, tag_reg};
            end
            SQ_DONE:
            begin
                load_out = !out_vld_reg || rsp.ready;
            end
            default:
            begin
                req.ready = 1'b0;
            end
        endcase
    end

    assign accept = req.valid && req.ready;

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= SQ_IDLE;
            out_vld_reg <= 1'b0;
            cmp_vld_reg <= 1'b0;
            wr_pend_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cmp_vld_reg <= scan_issue;
            wr_pend_reg <= shift_issue;
            if (load_out)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    // Held count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (state_reg == SQ_DECIDE)
        begin
            if (op_reg == OP_ENQ)
            begin
                if (!(found_reg && mkind_reg == kind_reg)
                    && count_reg != CNT_W'(QUEUE_DEPTH))
                begin
                    count_reg <= count_reg + 1'b1;
                end
            end
            else if (count_reg != '0)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // Datapath: capture, scan, decide, shift
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg       <= req.opcode;
            kind_reg     <= req.job_kind;
            prio_reg     <= req.job_priority;
            tag_reg      <= req.chunk_tag;
            favored_reg  <= (req.active_saves > req.active_loads) ? KIND_LOAD : KIND_SAVE;
            rd_idx_reg   <= '0;
            found_reg    <= 1'b0;
            pos0_vld_reg <= 1'b0;
            posx_vld_reg <= 1'b0;
            fav_vld_reg  <= 1'b0;
            pick_reg     <= '0;
        end

        // Advance the scan and compare the returned entry
        if (scan_issue)
        begin
            rd_idx_reg  <= rd_idx_reg + 1'b1;
            cmp_idx_reg <= rd_idx_reg;
        end
        if (state_reg == SQ_SCAN && cmp_vld_reg)
        begin
            if (first_hit)
            begin
                found_reg <= 1'b1;
                match_reg <= cmp_idx_reg;
                mkind_reg <= e_kind;
                mprio_reg <= e_prio;
            end
            if (!pos0_vld_reg && prio_reg > e_prio)
            begin
                pos0_vld_reg <= 1'b1;
                pos0_reg     <= cmp_idx_reg;
            end
            if (!posx_vld_reg && !first_hit && prio_reg > e_prio)
            begin
                posx_vld_reg <= 1'b1;
                posx_reg     <= cmp_idx_reg;
            end
            if (!fav_vld_reg && e_kind == favored_reg)
            begin
                fav_vld_reg <= 1'b1;
                pick_reg    <= cmp_idx_reg;
                pkind_reg   <= e_kind;
                pprio_reg   <= e_prio;
                ptag_reg    <= e_tag;
            end
            else if (!fav_vld_reg && cmp_idx_reg == '0)
            begin
                pkind_reg <= e_kind;
                pprio_reg <= e_prio;
                ptag_reg  <= e_tag;
            end
        end

        // Choose the outcome and set up the shift
        if (state_reg == SQ_DECIDE)
        begin
            left_reg <= '0;
            wnew_reg <= 1'b0;
            if (op_reg == OP_ENQ)
            begin
                if (found_reg && mkind_reg == kind_reg)
                begin
                    if (prio_reg > mprio_reg)
                    begin
                        status_reg <= ST_REPLACED;
                        wnew_reg   <= 1'b1;
                        if (posx_eff < match_reg)
                        begin
                            right_reg  <= 1'b1;
                            src_reg    <= match_reg - 1'b1;
                            left_reg   <= match_reg - posx_eff;
                            newpos_reg <= posx_eff;
                        end
                        else
                        begin
                            right_reg  <= 1'b0;
                            src_reg    <= match_reg + 1'b1;
                            left_reg   <= posx_eff - match_reg - 1'b1;
                            newpos_reg <= posx_eff - 1'b1;
                        end
                    end
                    else
                    begin
                        status_reg <= ST_DROPPED;
                    end
                end
                else if (count_reg == CNT_W'(QUEUE_DEPTH))
                begin
                    status_reg <= ST_FULL;
                end
                else
                begin
                    status_reg <= ST_INSERTED;
                    wnew_reg   <= 1'b1;
                    right_reg  <= 1'b1;
                    src_reg    <= count_reg - 1'b1;
                    left_reg   <= count_reg - pos0_eff;
                    newpos_reg <= pos0_eff;
                end
            end
            else if (count_reg == '0)
            begin
                status_reg <= ST_EMPTY;
            end
            else
            begin
                status_reg <= ST_DEQUEUED;
                right_reg  <= 1'b0;
                src_reg    <= pick_reg + 1'b1;
                left_reg   <= count_reg - pick_reg - 1'b1;
            end
        end

        // Move one entry a cycle
        if (shift_issue)
        begin
            left_reg    <= left_reg - 1'b1;
            src_reg     <= right_reg ? src_reg - 1'b1 : src_reg + 1'b1;
            wr_addr_reg <= right_reg ? src_reg + 1'b1 : src_reg - 1'b1;
        end

        // Load the result word
        if (load_out)
        begin
            if (status_reg == ST_DEQUEUED)
            begin
                res_kind_reg <= pkind_reg;
                res_prio_reg <= pprio_reg;
                res_tag_reg  <= ptag_reg;
            end
            else
            begin
                res_kind_reg <= 1'b0;
                res_prio_reg <= '0;
                res_tag_reg  <= '0;
            end
        end
    end

    logic [CNT_W-1:0] res_count_reg;
    status_t          res_status_reg;

    // Hold status and count with the result word
    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            res_status_reg <= status_reg;
            res_count_reg  <= count_reg;
        end
    end

    assign rsp.valid         = out_vld_reg;
    assign rsp.status        = res_status_reg;
    assign rsp.out_kind      = res_kind_reg;
    assign rsp.out_priority  = res_prio_reg;
    assign rsp.out_chunk_tag = res_tag_reg;
    assign rsp.queue_count   = res_count_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("held count above depth");

    a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
        scan_issue |-> rd_idx_reg < count_reg)
        else $error("scan read beyond held entries");

    a_shift_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == SQ_SHIFT && wr_pend_reg) |-> wr_addr_reg < count_reg)
        else $error("shift write beyond held entries");

    a_full_only: assert property (@(posedge clk) disable iff (!rst_n)
        (load_out && status_reg == ST_FULL) |-> count_reg == CNT_W'(QUEUE_DEPTH))
        else $error("full reported below depth");
endmodule
